// ----- sv/assert_macros.svh -----
// Assertion macros shared by the disparity winner-take-all RTL.
// Plain header, no dependencies; include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/dwta_pkg.sv -----
// Types and constants for the disparity winner-take-all block.
// No dependencies; imported by every module of the block.
package dwta_pkg;

   localparam int CostWidth  = 24;
   localparam int FracBits   = 14;
   localparam int IndexWidth = 8;
   localparam int AddrWidth  = 3;
   localparam int DataWidth  = 32;

   // highest disparity index the datapath honors
   localparam logic [9:0] MaxRange = 10'd255;

   localparam logic signed [CostWidth-1:0] CostMaxCode  = {1'b0, {(CostWidth-1){1'b1}}};
   localparam logic signed [CostWidth-1:0] CostMinusOne =
      CostWidth'(-(longint'(1) << FracBits));

   // register indexes, taken from paddr[2]
   localparam logic RegSelectMax      = 1'b0;
   localparam logic RegDisparityRange = 1'b1;

   typedef struct packed {
      logic signed [CostWidth-1:0] cost;
      logic                        pixel_valid;
   } dwta_req_type;

   typedef struct packed {
      logic [IndexWidth-1:0]       best_index;
      logic signed [CostWidth-1:0] best_cost;
      logic signed [CostWidth-1:0] second_cost;
      logic                        pixel_written;
   } dwta_rsp_type;

   typedef struct packed {
      logic                  select_max;
      logic [IndexWidth-1:0] disparity_range;
   } dwta_cfg_type;

   typedef struct packed {
      logic                  last;
      logic [IndexWidth-1:0] position;
   } dwta_status_type;

endpackage

// ----- sv/dwta_csr.sv -----
// APB-style configuration registers: select_max and disparity_range.
// Depends on dwta_pkg.
module dwta_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dwta_pkg::AddrWidth-1:0] paddr,
   input  logic [dwta_pkg::DataWidth-1:0] pwdata,
   output logic [dwta_pkg::DataWidth-1:0] prdata,
   output logic                          pready,
   output dwta_pkg::dwta_cfg_type         cfg
);
   import dwta_pkg::*;

   logic                  select_max_ff, select_max_in;
   logic [IndexWidth-1:0] range_ff, range_in;
   logic                  write_en;
   logic                  reg_sel;

   assign pready   = 1'b1;
   assign reg_sel  = paddr[2];
   assign write_en = psel && penable && pwrite;

   always_comb begin
      select_max_in = select_max_ff;
      range_in      = range_ff;
      if (write_en) begin
         unique case (reg_sel)
            RegSelectMax:      select_max_in = pwdata[0];
            RegDisparityRange: range_in      = pwdata[IndexWidth-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_max_ff <= 1'b1;
         range_ff      <= IndexWidth'(63);
      end else begin
         select_max_ff <= select_max_in;
         range_ff      <= range_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         RegSelectMax:      prdata = {{(DataWidth-1){1'b0}}, select_max_ff};
         RegDisparityRange: prdata = {{(DataWidth-IndexWidth){1'b0}}, range_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.select_max      = select_max_ff;
   assign cfg.disparity_range = range_ff;

endmodule

// ----- sv/dwta_core.sv -----
// Running best / second-best tracker: one cost per advance, result on a pixel's last cost.
// Depends on dwta_pkg.
module dwta_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  dwta_pkg::dwta_req_type     req,
   input  dwta_pkg::dwta_cfg_type     cfg,
   output dwta_pkg::dwta_rsp_type     rsp_next,
   output dwta_pkg::dwta_status_type  status
);
   import dwta_pkg::*;

   logic signed [CostWidth-1:0] best_ff, best_in;
   logic signed [CostWidth-1:0] second_ff, second_in;
   logic [IndexWidth-1:0]       index_ff, index_in;
   logic [IndexWidth-1:0]       pos_ff, pos_in;
   logic                        mask_ff, mask_in;
   logic [IndexWidth-1:0]       range_eff;
   logic                        last;
   logic                        better;
   logic                        beats_second;

   assign range_eff = ({2'b00, cfg.disparity_range} > MaxRange) ?
                      MaxRange[IndexWidth-1:0] : cfg.disparity_range;
   assign last      = (pos_ff >= range_eff);

   assign better       = cfg.select_max ? (req.cost > best_ff)   : (req.cost < best_ff);
   assign beats_second = cfg.select_max ? (req.cost > second_ff) : (req.cost < second_ff);

   always_comb begin
      best_in   = best_ff;
      second_in = second_ff;
      index_in  = index_ff;
      mask_in   = mask_ff;
      if (pos_ff == '0) begin
         // first cost of a pixel seeds the tracker
         mask_in   = req.pixel_valid;
         best_in   = req.cost;
         index_in  = '0;
         second_in = cfg.select_max ? CostMinusOne : CostMaxCode;
      end else begin
         priority if (better) begin
            second_in = best_ff;
            best_in   = req.cost;
            index_in  = pos_ff;
         end else if (beats_second) begin
            second_in = req.cost;
         end
      end
      pos_in = last ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff   <= '0;
         second_ff <= '0;
         index_ff  <= '0;
         pos_ff    <= '0;
         mask_ff   <= 1'b0;
      end else if (advance) begin
         best_ff   <= best_in;
         second_ff <= second_in;
         index_ff  <= index_in;
         pos_ff    <= pos_in;
         mask_ff   <= mask_in;
      end
   end

   // masked pixels report all-zero fields
   always_comb begin
      if (mask_in) begin
         rsp_next.best_index    = index_in;
         rsp_next.best_cost     = best_in;
         rsp_next.second_cost   = second_in;
         rsp_next.pixel_written = 1'b1;
      end else begin
         rsp_next = '0;
      end
   end

   assign status.last     = last;
   assign status.position = pos_ff;

endmodule

// ----- sv/disparity_winner_take_all.sv -----
// Disparity winner-take-all: streams matching costs in index order, disparity_range+1
// per pixel, and returns one result per pixel: best index, best cost, second-best cost
// and the pixel's mask bit. Costs enter at one per cycle with no bubbles between
// pixels while no last cost waits; a cost is registered on transfer and folded into
// the running best/second-best state when it advances (one compare pair on the state
// loop); a pixel's last cost also loads the pixel's result into the output register,
// which drives rsp_valid. Costs that do not end a pixel keep flowing while a result
// waits on rsp_stall; a pixel's last cost waits until the output register is free.
// Depends on dwta_pkg, dwta_csr, dwta_core and assert_macros.svh.
`include "assert_macros.svh"

module disparity_winner_take_all (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dwta_pkg::dwta_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dwta_pkg::dwta_rsp_type        rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [dwta_pkg::AddrWidth-1:0] paddr,
   input  logic [dwta_pkg::DataWidth-1:0] pwdata,
   output logic [dwta_pkg::DataWidth-1:0] prdata,
   output logic                          pready
);
   import dwta_pkg::*;

   dwta_cfg_type    cfg;
   dwta_status_type status;
   dwta_rsp_type    rsp_next;
   dwta_req_type    in_data_ff;
   dwta_rsp_type    rsp_data_ff;
   logic            in_valid_ff, in_valid_in;
   logic            out_valid_ff, out_valid_in;
   logic            out_free;
   logic            advance;
   logic            emit;
   logic            in_load;

   dwta_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dwta_core u_core (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .req      (in_data_ff),
      .cfg      (cfg),
      .rsp_next (rsp_next),
      .status   (status)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!status.last || out_free);
   assign emit      = advance && status.last;
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   assign in_valid_in  = in_load ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = emit ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_data_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_NEXT(a_pos_wraps, clock, reset, emit, status.position == '0, "pixel did not restart at index zero")
   `ASSERT_IMPLIES(a_masked_zero, clock, reset, out_valid_ff && !rsp_data_ff.pixel_written, (rsp_data_ff.best_index == '0) && (rsp_data_ff.best_cost == '0) && (rsp_data_ff.second_cost == '0), "masked pixel result not cleared")
   `ASSERT_IMPLIES(a_result_origin, clock, reset, $rose(out_valid_ff), $past(emit), "result appeared without a pixel end")

endmodule

// ----- sim/dwta_checker.sv -----
// Scoreboard for disparity_winner_take_all: tracks register writes, folds each cost
// transfer into a winner-take-all prediction and compares every result transfer.
// Depends on dwta_pkg.
`timescale 1ns / 100ps

module dwta_checker
   import dwta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  dwta_req_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  dwta_rsp_type         rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   input  logic                 pready,
   output int                   mismatches,
   output int                   outstanding
);

   logic                        select_max_q;
   logic [IndexWidth-1:0]       range_q;
   logic signed [CostWidth-1:0] best_q;
   logic signed [CostWidth-1:0] second_q;
   logic [IndexWidth-1:0]       index_q;
   logic [IndexWidth-1:0]       position_q;
   logic                        mask_q;
   dwta_rsp_type                winners_due[$];

   task automatic report(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic fold_cost(input dwta_req_type item);
      logic         beats_best;
      logic         beats_second;
      dwta_rsp_type winner;
      if (position_q == '0) begin
         mask_q   = item.pixel_valid;
         best_q   = item.cost;
         index_q  = '0;
         // start value of the runner-up is fixed by the mode seen on the first cost
         second_q = select_max_q ? CostMinusOne : CostMaxCode;
      end else begin
         beats_best   = select_max_q ? (item.cost > best_q) : (item.cost < best_q);
         beats_second = select_max_q ? (item.cost > second_q) : (item.cost < second_q);
         if (beats_best) begin
            second_q = best_q;
            best_q   = item.cost;
            index_q  = position_q;
         end else if (beats_second) begin
            second_q = item.cost;
         end
      end
      if (position_q >= range_q) begin
         winner = '0;
         if (mask_q) begin
            winner.best_index    = index_q;
            winner.best_cost     = best_q;
            winner.second_cost   = second_q;
            winner.pixel_written = 1'b1;
         end
         winners_due.insert(winners_due.size(), winner);
         position_q = '0;
      end else begin
         position_q = position_q + 1'b1;
      end
   endtask

   task automatic check_winner(input dwta_rsp_type got);
      dwta_rsp_type want;
      if (winners_due.size() == 0) begin
         report("result transfer with no pixel pending");
         return;
      end
      want = winners_due.pop_front();
      if (got.best_index !== want.best_index)
         report($sformatf("best_index got %0d want %0d", got.best_index, want.best_index));
      if (got.best_cost !== want.best_cost)
         report($sformatf("best_cost got %0d want %0d", got.best_cost, want.best_cost));
      if (got.second_cost !== want.second_cost)
         report($sformatf("second_cost got %0d want %0d", got.second_cost, want.second_cost));
      if (got.pixel_written !== want.pixel_written)
         report($sformatf("pixel_written got %0b want %0b", got.pixel_written,
                          want.pixel_written));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         select_max_q = 1'b1;
         range_q      = 8'd63;
         best_q       = '0;
         second_q     = '0;
         index_q      = '0;
         position_q   = '0;
         mask_q       = 1'b0;
         mismatches   = 0;
         winners_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == RegDisparityRange) range_q = pwdata[IndexWidth-1:0];
            else select_max_q = pwdata[0];
         end
         if (rsp_valid && !rsp_stall) check_winner(rsp_data);
         if (req_valid && !req_stall) fold_cost(req_data);
      end
      outstanding = winners_due.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// Top of the disparity_winner_take_all testbench: clock, reset, cost stream,
// result drain and register writes; dwta_checker does the prediction and compare.
// Depends on dwta_pkg, dwta_checker and the block itself.
`timescale 1ns / 100ps

module tb_top;
   import dwta_pkg::*;

   localparam int ItemBudget    = 500;
   localparam int WatchdogLimit = 1000;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   dwta_req_type         req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   dwta_rsp_type         rsp_data;
   logic                 psel      = 1'b0;
   logic                 penable   = 1'b0;
   logic                 pwrite    = 1'b0;
   logic [AddrWidth-1:0] paddr     = '0;
   logic [DataWidth-1:0] pwdata    = '0;
   logic [DataWidth-1:0] prdata;
   logic                 pready;

   int                   mismatches;
   int                   outstanding;
   int                   items_sent  = 0;
   int                   idle_cycles = 0;
   int                   cur_range   = 63;
   logic                 cur_mode    = 1'b1;
   logic                 calm_send   = 1'b0;
   logic                 calm_recv   = 1'b0;
   logic signed [CostWidth-1:0] last_cost = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   disparity_winner_take_all DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   dwta_checker winner_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   // random codes, extremes, exact ties and near ties to the previous cost
   function automatic logic signed [CostWidth-1:0] pick_cost(
      input logic signed [CostWidth-1:0] prev);
      logic signed [CostWidth-1:0] nudge;
      nudge = CostWidth'($urandom_range(0, 6));
      nudge = nudge - 24'sd3;
      case ($urandom_range(0, 7))
         0: pick_cost = CostMaxCode;
         1: pick_cost = {1'b1, {(CostWidth-1){1'b0}}};
         2: pick_cost = prev;
         3: pick_cost = prev + nudge;
         4: pick_cost = CostMinusOne;
         default: pick_cost = CostWidth'($urandom);
      endcase
   endfunction

   task automatic send_cost(input logic signed [CostWidth-1:0] c, input logic pv);
      int           gap;
      dwta_req_type item;
      gap = calm_send ? 0 : $urandom_range(0, 4);
      item.cost        = c;
      item.pixel_valid = pv;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      last_cost = c;
      items_sent++;
   endtask

   task automatic send_run(input int count);
      logic signed [CostWidth-1:0] c;
      repeat (count) begin
         c = pick_cost(last_cost);
         send_cost(c, $urandom_range(0, 4) != 0);
      end
   endtask

   // drain every pending result, then let any in-flight non-final costs settle
   task automatic settle_idle();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic sel, input logic [DataWidth-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // stop partway through a pixel, change mode or range, then finish the pixel
   task automatic split_pixel();
      int head;
      int rest;
      head = $urandom_range(1, cur_range);
      send_run(head);
      settle_idle();
      if ($urandom_range(0, 1) == 1) begin
         cur_mode = !cur_mode;
         csr_write(RegSelectMax, DataWidth'(cur_mode));
         rest = cur_range - head + 1;
      end else begin
         cur_range = $urandom_range(0, (cur_range < 252) ? cur_range + 3 : 255);
         csr_write(RegDisparityRange, cur_range);
         rest = (head >= cur_range) ? 1 : cur_range - head + 1;
      end
      send_run(rest);
   endtask

   initial begin : result_drain
      int hold;
      forever begin
         hold = calm_recv ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("[disparity_winner_take_all] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int phase;
      int draw;
      int pixels;
      int target;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // two-cost pixels in max mode: extremes, a tie, a masked pixel
      cur_range = 1;
      csr_write(RegDisparityRange, cur_range);
      send_cost(CostMaxCode, 1'b1);
      send_cost({1'b1, {(CostWidth-1){1'b0}}}, 1'b1);
      send_cost(24'sd5, 1'b1);
      send_cost(24'sd5, 1'b1);
      send_cost(24'sd100, 1'b0);
      send_cost(-24'sd200, 1'b1);
      settle_idle();
      cur_mode = 1'b0;
      csr_write(RegSelectMax, DataWidth'(cur_mode));
      send_cost({1'b1, {(CostWidth-1){1'b0}}}, 1'b1);
      send_cost(CostMaxCode, 1'b1);
      send_cost(-24'sd1, 1'b1);
      send_cost(-24'sd2, 1'b1);
      // range zero: every cost is a pixel
      settle_idle();
      cur_range = 0;
      csr_write(RegDisparityRange, cur_range);
      send_cost(24'sd0, 1'b1);
      send_cost(CostMinusOne, 1'b1);
      send_cost(24'sh123456, 1'b0);
      // range shrunk below the current position ends the pixel on the next cost
      settle_idle();
      cur_mode = 1'b1;
      csr_write(RegSelectMax, DataWidth'(cur_mode));
      cur_range = 3;
      csr_write(RegDisparityRange, cur_range);
      send_cost(24'sd10, 1'b1);
      send_cost(24'sd20, 1'b1);
      settle_idle();
      cur_range = 1;
      csr_write(RegDisparityRange, cur_range);
      send_cost(24'sd30, 1'b1);
      // mode flipped mid-pixel, after the max-mode runner-up start value was seeded
      send_cost(24'sd7, 1'b1);
      settle_idle();
      cur_mode = 1'b0;
      csr_write(RegSelectMax, DataWidth'(cur_mode));
      send_cost(24'sd3, 1'b1);

      target = items_sent + ItemBudget;
      phase  = 0;
      while (items_sent < target) begin
         settle_idle();
         calm_send = ($urandom_range(0, 3) == 0);
         calm_recv = ($urandom_range(0, 3) == 0);
         cur_mode  = 1'($urandom_range(0, 1));
         draw      = $urandom_range(0, 19);
         if (phase == 3) cur_range = 255;
         else if (draw == 0) cur_range = 0;
         else if (draw == 1) cur_range = $urandom_range(8, 40);
         else cur_range = $urandom_range(1, 6);
         csr_write(RegSelectMax, DataWidth'(cur_mode));
         csr_write(RegDisparityRange, cur_range);
         pixels = (cur_range > 40) ? 1 : $urandom_range(2, 8);
         repeat (pixels) begin
            if (cur_range != 0 && $urandom_range(0, 9) == 0) split_pixel();
            else send_run(cur_range + 1);
         end
         phase++;
      end

      settle_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) $display("[disparity_winner_take_all] OK");
      else $display("[disparity_winner_take_all] ERROR");
      $finish;
   end

endmodule
